FILE: rtl/core/kwsm_pkg.sv
package kwsm_pkg;

	// default sizes of the merge core
	localparam int NUM_LISTS_DEF   = 8;
	localparam int LIST_DEPTH_DEF  = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// result status codes
	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} kwsm_status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH,
		S_POP,
		S_REFILL
	} kwsm_state_t;

endpackage

FILE: rtl/core/kwsm_min_tree.sv
module kwsm_min_tree #(
	parameter int NUM_LISTS   = kwsm_pkg::NUM_LISTS_DEF,
	parameter int VALUE_WIDTH = kwsm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NUM_LISTS-1:0]          leaf_vld,
	input  logic signed [VALUE_WIDTH-1:0] leaf_val [NUM_LISTS],
	output logic                          found,
	output logic [$clog2(NUM_LISTS)-1:0]  best_idx,
	output logic signed [VALUE_WIDTH-1:0] best_val
);

	localparam int LW = $clog2(NUM_LISTS);
	localparam int P  = 1 << LW;

	// leaves, padded up to a power of two with empty entries
	logic [P-1:0]                  lf_v;
	logic signed [VALUE_WIDTH-1:0] lf_val [P];

	// registered inner nodes in heap order, node 1 is the root
	logic [P-1:1]                  nd_v;
	logic signed [VALUE_WIDTH-1:0] nd_val [P-1:1];
	logic [LW-1:0]                 nd_idx [P-1:1];

	genvar l, n;

	for (l = 0; l < P; l++) begin : g_leaf
		if (l < NUM_LISTS) begin : g_used
			assign lf_v[l]   = leaf_vld[l];
			assign lf_val[l] = leaf_val[l];
		end else begin : g_pad
			assign lf_v[l]   = 1'b0;
			assign lf_val[l] = '0;
		end
	end

	for (n = 1; n < P; n++) begin : g_node
		logic                          lv, rv;
		logic signed [VALUE_WIDTH-1:0] lval, rval;
		logic [LW-1:0]                 lidx, ridx;
		logic                          take_r;

		if (2 * n >= P) begin : g_from_leaf
			localparam int LI = 2 * n - P;
			assign lv   = lf_v[LI];
			assign rv   = lf_v[LI+1];
			assign lval = lf_val[LI];
			assign rval = lf_val[LI+1];
			assign lidx = LW'(LI);
			assign ridx = LW'(LI + 1);
		end else begin : g_from_node
			assign lv   = nd_v[2*n];
			assign rv   = nd_v[2*n+1];
			assign lval = nd_val[2*n];
			assign rval = nd_val[2*n+1];
			assign lidx = nd_idx[2*n];
			assign ridx = nd_idx[2*n+1];
		end

		// higher index side wins a tie
		assign take_r = rv && (!lv || (rval <= lval));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nd_v[n] <= 1'b0;
			end else begin
				nd_v[n] <= lv || rv;
			end
		end

		always_ff @(posedge clk) begin
			nd_val[n] <= take_r ? rval : lval;
			nd_idx[n] <= take_r ? ridx : lidx;
		end
	end

	assign found    = nd_v[1];
	assign best_idx = nd_idx[1];
	assign best_val = nd_val[1];

endmodule

FILE: rtl/core/k_way_sorted_merge_core.sv
// channel | handshake           | fields
// --------+---------------------+------------------------------------------
// command | start, busy         | action, list_select, value
// result  | done (one cycle)    | status, merged_value, source_list
//
// a push runs in the S_PUSH state after accept, and done is registered from it
// a pop waits in S_POP for the registered minimum tree to settle after the last
// head change, and when the list keeps entries, passes through S_REFILL, still
// busy, for the head refill read from the value memory; a further command is only
// accepted once the sequencer is back in S_IDLE
// reset clears fill counts and head pointers at once; the value memory is not
// cleared, only written entries are read
// done pulses for one cycle and cannot be held off by the receiver
module k_way_sorted_merge_core #(
	parameter int NUM_LISTS   = kwsm_pkg::NUM_LISTS_DEF,
	parameter int LIST_DEPTH  = kwsm_pkg::LIST_DEPTH_DEF,
	parameter int VALUE_WIDTH = kwsm_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [2:0]         list_select,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] merged_value,
	output logic [2:0]         source_list
);

	localparam int LW  = $clog2(NUM_LISTS);
	localparam int DW  = $clog2(LIST_DEPTH);
	localparam int FW  = $clog2(LIST_DEPTH + 1);
	localparam int AW  = LW + DW;
	localparam int XW  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam int SCW = $clog2(LW + 1);
	localparam logic [SCW-1:0] SETTLE_INIT = SCW'(LW);

	kwsm_pkg::kwsm_state_t state_q, state_d;

	// captured command word
	logic                          sel_ok_q;
	logic [LW-1:0]                 sel_idx_q;
	logic [VALUE_WIDTH-1:0]        push_val_q;

	// per-list control state and cached heads
	logic [FW-1:0]                 fill_q     [NUM_LISTS];
	logic [DW-1:0]                 hptr_q     [NUM_LISTS];
	logic signed [VALUE_WIDTH-1:0] head_val_q [NUM_LISTS];
	logic [NUM_LISTS-1:0]          head_vld;

	// value memory, one ring of LIST_DEPTH slots per list
	logic [VALUE_WIDTH-1:0]        mem [2**AW];
	logic [VALUE_WIDTH-1:0]        rd_q;

	logic [LW-1:0]                 pop_idx_q;
	logic [SCW-1:0]                settle_q;

	// result registers
	logic                          done_q;
	logic [1:0]                    status_q;
	logic signed [31:0]            merged_q;
	logic [2:0]                    source_q;

	// tree outputs
	logic                          t_found;
	logic [LW-1:0]                 t_idx;
	logic signed [VALUE_WIDTH-1:0] t_val;

	// decoded command and datapath
	logic                          accept;
	logic [LW+2:0]                 sel_wide;
	logic signed [XW-1:0]          val_ext;
	logic signed [XW-1:0]          pop_ext;
	logic [LW-1:0]                 op_idx;
	logic [FW-1:0]                 fill_rd;
	logic [DW-1:0]                 hptr_rd;
	logic [DW:0]                   tail_sum;
	logic [DW-1:0]                 tail;
	logic [DW-1:0]                 head_next;
	logic                          full;

	// control strobes
	logic                          done_d;
	kwsm_pkg::kwsm_status_t        status_d;
	logic signed [31:0]            merged_d;
	logic [2:0]                    source_d;
	logic                          push_we;
	logic                          pop_we;
	logic                          mem_re;
	logic                          refill_load;

	assign busy   = (state_q != kwsm_pkg::S_IDLE);
	assign accept = start && !busy;

	// command decode
	assign sel_wide = (LW + 3)'(list_select);
	assign val_ext  = XW'(value);
	assign pop_ext  = XW'(t_val);

	// list valid flags feed the tree leaves
	always_comb begin
		for (int i = 0; i < NUM_LISTS; i++) begin
			head_vld[i] = (fill_q[i] != '0);
		end
	end

	kwsm_min_tree #(
		.NUM_LISTS  (NUM_LISTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.leaf_vld(head_vld),
		.leaf_val(head_val_q),
		.found   (t_found),
		.best_idx(t_idx),
		.best_val(t_val)
	);

	// single read of the per-list control state
	assign op_idx  = (state_q == kwsm_pkg::S_POP) ? t_idx : sel_idx_q;
	assign fill_rd = fill_q[op_idx];
	assign hptr_rd = hptr_q[op_idx];

	// ring arithmetic, sums stay below twice the depth
	assign tail_sum  = (DW + 1)'(hptr_rd) + (DW + 1)'(fill_rd);
	assign tail      = (tail_sum >= (DW + 1)'(LIST_DEPTH)) ?
	                   DW'(tail_sum - (DW + 1)'(LIST_DEPTH)) : DW'(tail_sum);
	assign head_next = ((DW + 1)'(hptr_rd) + (DW + 1)'(1) == (DW + 1)'(LIST_DEPTH)) ?
	                   '0 : DW'((DW + 1)'(hptr_rd) + (DW + 1)'(1));
	assign full      = !sel_ok_q || (fill_rd == FW'(LIST_DEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kwsm_pkg::S_IDLE: begin
				if (accept) begin
					state_d = action ? kwsm_pkg::S_POP : kwsm_pkg::S_PUSH;
				end
			end
			kwsm_pkg::S_PUSH: begin
				state_d = kwsm_pkg::S_IDLE;
			end
			kwsm_pkg::S_POP: begin
				if (settle_q == '0) begin
					if (t_found && (fill_rd > FW'(1))) begin
						state_d = kwsm_pkg::S_REFILL;
					end else begin
						state_d = kwsm_pkg::S_IDLE;
					end
				end
			end
			kwsm_pkg::S_REFILL: begin
				state_d = kwsm_pkg::S_IDLE;
			end
			default: begin
				state_d = kwsm_pkg::S_IDLE;
			end
		endcase
	end

	// outputs and update strobes
	always_comb begin
		done_d      = 1'b0;
		status_d    = kwsm_pkg::ST_PUSHED;
		merged_d    = '0;
		source_d    = '0;
		push_we     = 1'b0;
		pop_we      = 1'b0;
		mem_re      = 1'b0;
		refill_load = 1'b0;
		case (state_q)
			kwsm_pkg::S_PUSH: begin
				done_d = 1'b1;
				if (full) begin
					status_d = kwsm_pkg::ST_FULL;
				end else begin
					status_d = kwsm_pkg::ST_PUSHED;
					push_we  = 1'b1;
				end
			end
			kwsm_pkg::S_POP: begin
				if (settle_q == '0) begin
					done_d = 1'b1;
					if (!t_found) begin
						status_d = kwsm_pkg::ST_EMPTY;
					end else begin
						status_d = kwsm_pkg::ST_POPPED;
						merged_d = pop_ext[31:0];
						source_d = 3'(t_idx);
						pop_we   = 1'b1;
						mem_re   = (fill_rd > FW'(1));
					end
				end
			end
			kwsm_pkg::S_REFILL: begin
				refill_load = 1'b1;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kwsm_pkg::S_IDLE;
			done_q   <= 1'b0;
			settle_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (push_we || pop_we || refill_load) begin
				settle_q <= SETTLE_INIT;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		merged_q <= merged_d;
		source_q <= source_d;
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_ok_q   <= (sel_wide < (LW + 3)'(NUM_LISTS));
			sel_idx_q  <= sel_wide[LW-1:0];
			push_val_q <= val_ext[VALUE_WIDTH-1:0];
		end
		if (pop_we) begin
			pop_idx_q <= t_idx;
		end
	end

	// fill counts and head pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				fill_q[i] <= '0;
				hptr_q[i] <= '0;
			end
		end else if (push_we) begin
			fill_q[sel_idx_q] <= fill_rd + FW'(1);
		end else if (pop_we) begin
			fill_q[t_idx] <= fill_rd - FW'(1);
			hptr_q[t_idx] <= head_next;
		end
	end

	// cached head values
	always_ff @(posedge clk) begin
		if (push_we && (fill_rd == '0)) begin
			head_val_q[sel_idx_q] <= push_val_q;
		end else if (refill_load) begin
			head_val_q[pop_idx_q] <= rd_q;
		end
	end

	// value memory, busy keeps a read and a write of one entry apart
	always_ff @(posedge clk) begin
		if (push_we) begin
			mem[{sel_idx_q, tail}] <= push_val_q;
		end
		if (mem_re) begin
			rd_q <= mem[{t_idx, head_next}];
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign merged_value = merged_q;
	assign source_list  = source_q;

`ifndef SYNTHESIS
	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a command in flight");

	// nothing to pop only when every list is empty
	a_empty_means_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == kwsm_pkg::ST_EMPTY)) |-> (head_vld == '0))
		else $error("empty status with a non-empty list");

	// a pop decision is taken from a settled tree
	a_pop_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == kwsm_pkg::ST_POPPED)) |-> ($past(settle_q) == '0))
		else $error("pop taken from an unsettled minimum tree");

	// data fields stay zero unless a value was popped
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != kwsm_pkg::ST_POPPED)) |->
		((merged_value == '0) && (source_list == '0)))
		else $error("data fields not zero on a non-pop result");
`endif

endmodule

FILE: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NL         = kwsm_pkg::NUM_LISTS_DEF;
	localparam int DEPTH      = kwsm_pkg::LIST_DEPTH_DEF;
	localparam int ITEM_GOAL  = 1900;
	localparam int QUIET_TAIL = 150;

	// command codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef struct {
		logic               act;
		logic [2:0]         sel;
		logic signed [31:0] val;
		bit                 drain_first;
	} merge_cmd_t;

	typedef struct {
		kwsm_pkg::kwsm_status_t status;
		logic signed [31:0]     value;
		logic [2:0]             src;
	} merge_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               action = 1'b0;
	logic [2:0]         list_select = 3'd0;
	logic signed [31:0] value = 32'sd0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] merged_value;
	logic [2:0]         source_list;

	merge_cmd_t    cmd_queue[$];
	merge_result_t merge_results_due[$];
	int            mismatch_count = 0;
	bit            cmd_taken = 1'b0;
	int            idle_left = 0;
	bit            idle_on = 1'b1;

	// shadow of the list memories
	logic signed [31:0] list_mem [NL][DEPTH];
	int                 list_head [NL];
	int                 list_fill [NL];

	// stimulus bookkeeping
	longint list_tail [NL];
	int     gen_count = 0;
	int     unsettled_pushes = 0;

	k_way_sorted_merge_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.list_select  (list_select),
		.value        (value),
		.done         (done),
		.status       (status),
		.merged_value (merged_value),
		.source_list  (source_list)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// apply one command to the shadow lists and return the merge outcome
	function automatic merge_result_t predict_merge(input merge_cmd_t c);
		merge_result_t r;
		int            pick;
		int            slot;
		r.status = kwsm_pkg::ST_PUSHED;
		r.value  = '0;
		r.src    = '0;
		if (c.act == ACT_PUSH) begin
			if (int'(c.sel) >= NL || list_fill[c.sel] >= DEPTH) begin
				r.status = kwsm_pkg::ST_FULL;
			end else begin
				slot = (list_head[c.sel] + list_fill[c.sel]) % DEPTH;
				list_mem[c.sel][slot] = c.val;
				list_fill[c.sel]++;
			end
		end else begin
			// smallest head wins, ties go to the higher list index
			pick = -1;
			for (int i = 0; i < NL; i++) begin
				if (list_fill[i] != 0 && (pick < 0 ||
						list_mem[i][list_head[i]] <= list_mem[pick][list_head[pick]]))
					pick = i;
			end
			if (pick < 0) begin
				r.status = kwsm_pkg::ST_EMPTY;
			end else begin
				r.status = kwsm_pkg::ST_POPPED;
				r.value  = list_mem[pick][list_head[pick]];
				r.src    = pick[2:0];
				list_head[pick] = (list_head[pick] + 1) % DEPTH;
				list_fill[pick]--;
			end
		end
		return r;
	endfunction

	// check result words, queue predictions for accepted words
	always @(posedge clk) begin : monitor
		merge_result_t due;
		merge_cmd_t    c;
		if (arst_n) begin
			if (done) begin
				if (merge_results_due.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					due = merge_results_due.pop_front();
					if (status !== due.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							status, due.status));
					if (merged_value !== due.value)
						report_mismatch($sformatf("merged_value got %0d expected %0d",
							merged_value, due.value));
					if (source_list !== due.src)
						report_mismatch($sformatf("source_list got %0d expected %0d",
							source_list, due.src));
				end
			end
			if (start && !busy) begin
				c.act         = action;
				c.sel         = list_select;
				c.val         = value;
				c.drain_first = 1'b0;
				merge_results_due.push_back(predict_merge(c));
			end
			cmd_taken <= start && !busy;
		end
	end

	// present queued command words, with random idle bursts
	always @(negedge clk) begin : driver
		logic               nxt_start;
		logic               nxt_action;
		logic [2:0]         nxt_sel;
		logic signed [31:0] nxt_value;
		nxt_start  = start;
		nxt_action = action;
		nxt_sel    = list_select;
		nxt_value  = value;
		if (arst_n) begin
			if (start && cmd_taken) begin
				void'(cmd_queue.pop_front());
				nxt_start = 1'b0;
			end
			if ($urandom_range(0, 99) == 0)
				idle_on = !idle_on;
			if (!nxt_start) begin
				// junk on the fields while idle
				nxt_action = 1'($urandom_range(0, 1));
				nxt_sel    = 3'($urandom_range(0, 7));
				nxt_value  = $urandom;
				if (idle_left > 0) begin
					idle_left--;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].drain_first && merge_results_due.size() != 0)) begin
					if (idle_on && cmd_queue.size() > QUIET_TAIL &&
							$urandom_range(0, 5) == 0) begin
						idle_left = $urandom_range(1, 11) - 1;
					end else begin
						nxt_start  = 1'b1;
						nxt_action = cmd_queue[0].act;
						nxt_sel    = cmd_queue[0].sel;
						nxt_value  = cmd_queue[0].val;
					end
				end
			end
		end
		start       <= nxt_start;
		action      <= nxt_action;
		list_select <= nxt_sel;
		value       <= nxt_value;
	end

	task automatic add_cmd(input logic act, input int sel, input logic signed [31:0] val,
			input bit drain);
		merge_cmd_t c;
		c.act         = act;
		c.sel         = sel[2:0];
		c.val         = val;
		c.drain_first = drain;
		cmd_queue.push_back(c);
		gen_count++;
		if (act == ACT_PUSH)
			unsettled_pushes++;
	endtask

	// mostly ascending per list, with an occasional out-of-order value
	task automatic add_push(input int sel, input bit drain);
		longint nv;
		longint step;
		if ($urandom_range(0, 19) == 0) begin
			add_cmd(ACT_PUSH, sel, $urandom, drain);
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: step = 0;
				3, 4, 5, 6: step = $urandom_range(1, 15);
				7, 8: step = $urandom_range(16, 1 << 20);
				default: step = longint'($urandom);
			endcase
			nv = list_tail[sel] + step;
			if (nv > 64'sd2147483647)
				nv = 64'sd2147483647;
			list_tail[sel] = nv;
			add_cmd(ACT_PUSH, sel, nv[31:0], drain);
		end
	endtask

	task automatic add_pop(input bit drain);
		add_cmd(ACT_POP, $urandom_range(0, 7), $urandom, drain);
	endtask

	task automatic restart_tails();
		for (int i = 0; i < NL; i++)
			list_tail[i] = longint'(int'($urandom) >>> $urandom_range(0, 24));
	endtask

	// one phase of random traffic of the given flavor
	task automatic gen_phase(input int kind, input bit drain);
		int n;
		int sel;
		bit d;
		d = drain;
		if (kind <= 3) begin
			// mixed traffic
			n = $urandom_range(10, 60);
			repeat (n) begin
				if ($urandom_range(0, 9) < 4)
					add_pop(d);
				else
					add_push($urandom_range(0, 7), d);
				d = 1'b0;
			end
		end else if (kind <= 5) begin
			// push heavy
			n = $urandom_range(30, 90);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					add_pop(d);
				else
					add_push($urandom_range(0, 7), d);
				d = 1'b0;
			end
		end else if (kind == 6) begin
			// overfill one list
			sel = $urandom_range(0, 7);
			n = DEPTH + $urandom_range(1, 6);
			repeat (n) begin
				add_push(sel, d);
				d = 1'b0;
			end
		end else if (kind <= 8) begin
			// drain everything, then a few pops on empty lists
			n = unsettled_pushes + $urandom_range(1, 3);
			repeat (n) begin
				add_pop(d);
				d = 1'b0;
			end
			restart_tails();
			unsettled_pushes = 0;
		end else begin
			// noise
			repeat (20) begin
				add_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom, d);
				d = 1'b0;
			end
		end
	endtask

	initial begin
		// directed: empty pop, extreme values, four-way tie at zero
		add_pop(1'b0);
		add_cmd(ACT_PUSH, 0, 32'h8000_0000, 1'b0);
		add_cmd(ACT_PUSH, 7, 32'h7fff_ffff, 1'b0);
		add_cmd(ACT_PUSH, 3, 32'sd0, 1'b0);
		add_cmd(ACT_PUSH, 2, 32'sd0, 1'b0);
		add_cmd(ACT_PUSH, 5, 32'sd0, 1'b0);
		add_cmd(ACT_PUSH, 4, 32'sd0, 1'b0);
		add_cmd(ACT_PUSH, 1, -32'sd1, 1'b0);
		add_cmd(ACT_PUSH, 6, 32'sd1, 1'b0);
		repeat (9) add_pop(1'b0);
		restart_tails();
		unsettled_pushes = 0;

		// random part, first phase fills a list past full after a pause
		gen_phase(6, 1'b1);
		while (gen_count < ITEM_GOAL)
			gen_phase($urandom_range(0, 9), $urandom_range(0, 2) == 0);
		gen_phase(7, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || merge_results_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && merge_results_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#500_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: k_way_sorted_merge_core.f
rtl/core/kwsm_pkg.sv
rtl/core/kwsm_min_tree.sv
rtl/core/k_way_sorted_merge_core.sv
dv/tb.sv
